// ===== hw/rtl/row_duplicate_filter_macros.svh =====
// assertion macros used by the row duplicate filter sequencer (rdf_seq)
`ifndef ROW_DUPLICATE_FILTER_MACROS_SVH
`define ROW_DUPLICATE_FILTER_MACROS_SVH

`ifndef SYNTHESIS
// plain property check on the module clock, muted during reset
`define RDF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// implication check: when the condition holds the consequence must hold
`define RDF_ASSERT_IMPL(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error(msg);
`else
`define RDF_ASSERT(lbl, prop, msg)
`define RDF_ASSERT_IMPL(lbl, cond, cons, msg)
`endif

`endif

// ===== hw/rtl/rdf_pkg.sv =====
// shared types, constants and helpers of the row duplicate filter
`timescale 1ns / 1ps

package rdf_pkg;

  // row geometry
  localparam int unsigned RowSlots = 8;
  localparam int unsigned ElemW    = 8;
  localparam int unsigned RowW     = RowSlots * ElemW;

  // row store geometry and counters
  localparam int unsigned MaxRows      = 1024;
  localparam int unsigned AddrW        = $clog2(MaxRows);
  localparam int unsigned CountW       = AddrW + 1;
  localparam int unsigned NumW         = 10;
  localparam int unsigned RowNumberMax = 1023;

  // configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 4;
  localparam int unsigned WinStartW = 3;
  localparam int unsigned WinLenW   = 4;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgWindowStart  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgWindowLength = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } seq_state_e;

  // input word
  typedef struct packed {
    logic [RowW-1:0] row_elements;
    logic            start_new_list;
  } row_in_t;

  // result word
  typedef struct packed {
    logic              is_duplicate;
    logic [NumW-1:0]   row_number;
    logic [CountW-1:0] unique_count;
    logic              store_full;
  } row_out_t;

  // row store access from the sequencer
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [RowW-1:0]  wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  // one bit per slot inside the window, clipped at the last slot
  function automatic logic [RowSlots-1:0] window_byte_mask(
    input logic [WinStartW-1:0] win_start,
    input logic [WinLenW-1:0]   win_len
  );
    logic [RowSlots-1:0] m;
    logic [WinLenW:0]    stop;
    m    = '0;
    stop = {2'b00, win_start} + {1'b0, win_len};
    for (int s = 0; s < RowSlots; s++) begin
      m[s] = ((WinLenW+1)'(s) >= {2'b00, win_start}) && ((WinLenW+1)'(s) < stop);
    end
    return m;
  endfunction

endpackage

// ===== hw/rtl/rdf_row_mem.sv =====
// unique row store: one write port, one registered read port
`timescale 1ns / 1ps

module rdf_row_mem (
  input  logic                        clk_i,
  input  rdf_pkg::mem_req_t           req_i,
  output logic [rdf_pkg::RowW-1:0]    rd_data_o
);
  import rdf_pkg::*;

  logic [RowW-1:0] mem_q [MaxRows];
  logic [RowW-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_data_q <= mem_q[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/rdf_seq.sv =====
// scan sequencer with the shared masked row comparator
`timescale 1ns / 1ps
`include "row_duplicate_filter_macros.svh"

module rdf_seq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  rdf_pkg::row_in_t                item_i,
  input  logic [rdf_pkg::RowSlots-1:0]    byte_mask_i,
  output rdf_pkg::mem_req_t               mem_req_o,
  input  logic [rdf_pkg::RowW-1:0]        rd_data_i,
  output logic                            done_o,
  output rdf_pkg::row_out_t               result_o
);
  import rdf_pkg::*;

  seq_state_e          state_q, state_d;
  logic [RowW-1:0]     row_q, row_d;
  logic [RowSlots-1:0] bmask_q, bmask_d;
  logic [CountW-1:0]   kept_q, kept_d;
  logic [NumW-1:0]     seen_q, seen_d;
  logic [CountW-1:0]   addr_q, addr_d;
  logic                rd_vld_q, rd_vld_d;
  logic                dup_q, dup_d;

  logic                issue;
  logic                match;
  logic [RowSlots-1:0] byte_eq;
  logic                store_full;
  logic                store_inc;

  // shared comparator: every windowed byte of the stored row must agree
  always_comb begin
    for (int b = 0; b < RowSlots; b++) begin
      byte_eq[b] = !bmask_q[b] || (rd_data_i[b*ElemW +: ElemW] == row_q[b*ElemW +: ElemW]);
    end
  end
  assign match = &byte_eq;

  // a read goes out while kept rows remain unvisited
  assign issue      = (state_q == ST_SCAN) && (addr_q < kept_q);
  assign store_full = !dup_q && (kept_q >= CountW'(MaxRows));
  assign store_inc  = !dup_q && !store_full;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_vld_q && match) begin
          state_d = ST_FIN;
        end else if (!issue && !rd_vld_q) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // datapath updates
  always_comb begin
    row_d    = row_q;
    bmask_d  = bmask_q;
    kept_d   = kept_q;
    seen_d   = seen_q;
    addr_d   = addr_q;
    rd_vld_d = rd_vld_q;
    dup_d    = dup_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          row_d    = item_i.row_elements;
          bmask_d  = byte_mask_i;
          addr_d   = '0;
          rd_vld_d = 1'b0;
          dup_d    = 1'b0;
          if (item_i.start_new_list) begin
            kept_d = '0;
            seen_d = '0;
          end
        end
      end
      ST_SCAN: begin
        rd_vld_d = issue;
        if (issue) begin
          addr_d = addr_q + 1'b1;
        end
        if (rd_vld_q && match) begin
          dup_d = 1'b1;
        end
      end
      ST_FIN: begin
        if (store_inc) begin
          kept_d = kept_q + 1'b1;
        end
        if (seen_q < NumW'(RowNumberMax)) begin
          seen_d = seen_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // outputs
  always_comb begin
    busy                  = (state_q != ST_IDLE);
    done_o                = (state_q == ST_FIN);
    result_o.is_duplicate = dup_q;
    result_o.row_number   = seen_q;
    result_o.unique_count = store_inc ? kept_q + 1'b1 : kept_q;
    result_o.store_full   = store_full;
    mem_req_o.we          = (state_q == ST_FIN) && store_inc;
    mem_req_o.waddr       = kept_q[AddrW-1:0];
    mem_req_o.wdata       = row_q;
    mem_req_o.re          = issue;
    mem_req_o.raddr       = addr_q[AddrW-1:0];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      kept_q   <= '0;
      seen_q   <= '0;
      addr_q   <= '0;
      rd_vld_q <= 1'b0;
      dup_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      kept_q   <= kept_d;
      seen_q   <= seen_d;
      addr_q   <= addr_d;
      rd_vld_q <= rd_vld_d;
      dup_q    <= dup_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    row_q   <= row_d;
    bmask_q <= bmask_d;
  end

  // checks
  `RDF_ASSERT(a_kept_bounded, kept_q <= CountW'(MaxRows), "kept count past store depth")
  `RDF_ASSERT(a_addr_bounded, addr_q <= kept_q, "scan address past kept rows")
  `RDF_ASSERT_IMPL(a_done_single, done_o, ##1 !done_o, "result strobe held two cycles")
  `RDF_ASSERT_IMPL(a_write_new_only, mem_req_o.we, !dup_q && (kept_q < CountW'(MaxRows)),
                   "store write for a duplicate or a full store")

endmodule

// ===== hw/rtl/row_duplicate_filter.sv =====
// row duplicate filter top level: configuration registers, sequencer and row store
//
//   channel   direction  handshake              word
//   input     in         start / busy           item_i (row_in_t)
//   result    out        done_o strobe          result_o (row_out_t)
//   config    in         cfg_we_i               cfg_idx_i, cfg_data_i
//
// with no match a row holds busy while every kept row is read and compared; with an empty
// store no read goes out; the next row can be taken as soon as busy falls
// a match ends the scan at the matching kept row; the single read port of the row store
// visits one kept row per cycle and each compare lands in the cycle after its read
// reset clears counters and sets the window to the whole row; the row store is not cleared
// the result strobe is the last busy cycle; the receiver cannot stall the block
`timescale 1ns / 1ps

module row_duplicate_filter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  rdf_pkg::row_in_t                item_i,
  output logic                            done_o,
  output rdf_pkg::row_out_t               result_o,
  input  logic                            cfg_we_i,
  input  logic [rdf_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [rdf_pkg::CfgDataW-1:0]    cfg_data_i
);
  import rdf_pkg::*;

  logic [WinStartW-1:0] win_start_q, win_start_d;
  logic [WinLenW-1:0]   win_len_q, win_len_d;
  logic [RowSlots-1:0]  byte_mask;
  mem_req_t             mem_req;
  logic [RowW-1:0]      rd_data;

  // register write decode
  always_comb begin
    win_start_d = win_start_q;
    win_len_d   = win_len_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgWindowStart:  win_start_d = cfg_data_i[WinStartW-1:0];
        CfgWindowLength: win_len_d   = cfg_data_i[WinLenW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q <= '0;
      win_len_q   <= WinLenW'(RowSlots);
    end else begin
      win_start_q <= win_start_d;
      win_len_q   <= win_len_d;
    end
  end

  // slots taking part in the comparison
  assign byte_mask = window_byte_mask(win_start_q, win_len_q);

  rdf_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .byte_mask_i (byte_mask),
    .mem_req_o   (mem_req),
    .rd_data_i   (rd_data),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  rdf_row_mem u_mem (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

endmodule
